// File: rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg - shared types and helpers for the JSON string unescaper
// Holds the decoder state, result entry types, result codes and the small
// character helpers: hex digit value, simple escapes and UTF-8 encoding.
// ----------------------------------------------------------------------------
package jsu_pkg;

   localparam int MAX_RESULTS = 6;
   localparam int RES_IDX_W   = $clog2(MAX_RESULTS);
   localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
   localparam int CP_W        = 21;

   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_U         = 8'h75;
   localparam logic [7:0] CH_SPACE     = 8'h20;

   localparam logic [CP_W-1:0] CP_REPLACEMENT = 21'h00FFFD;
   localparam logic [CP_W-1:0] CP_SUPP_BASE   = 21'h010000;
   localparam logic [15:0]     SURR_HIGH_MIN  = 16'hD800;
   localparam logic [15:0]     SURR_HIGH_MAX  = 16'hDBFF;
   localparam logic [15:0]     SURR_LOW_MIN   = 16'hDC00;
   localparam logic [15:0]     SURR_LOW_MAX   = 16'hDFFF;

   // UTF-8 form of U+FFFD.
   localparam logic [7:0] FFFD_B0 = 8'hEF;
   localparam logic [7:0] FFFD_B1 = 8'hBF;
   localparam logic [7:0] FFFD_B2 = 8'hBD;

   typedef enum logic [2:0] {
      MODE_WAIT = 3'd0,
      MODE_STR  = 3'd1,
      MODE_ESC  = 3'd2,
      MODE_HEX  = 3'd3
   } mode_type;

   typedef enum logic [1:0] {
      KIND_DATA = 2'd0,
      KIND_DONE = 2'd1,
      KIND_ERR  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE     = 3'd0,
      ERR_NO_QUOTE = 3'd1,
      ERR_CTRL     = 3'd2,
      ERR_ESCAPE   = 3'd3,
      ERR_HEX      = 3'd4,
      ERR_UNTERM   = 3'd5
   } err_type;

   typedef struct packed {
      mode_type    mode;
      logic [1:0]  hex_count;
      logic [15:0] hex_accum;
      logic [9:0]  pending_high;
      logic        pending_valid;
   } state_type;

   localparam state_type STATE_RESET = '{
      mode:          MODE_WAIT,
      hex_count:     2'd0,
      hex_accum:     16'd0,
      pending_high:  10'd0,
      pending_valid: 1'b0
   };

   typedef struct packed {
      logic [7:0] data;
      kind_type   kind;
      err_type    code;
   } result_type;

   typedef struct packed {
      result_type [MAX_RESULTS-1:0] entry;
      logic [RES_CNT_W-1:0]         count;
   } result_list_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] value;
   } esc_type;

   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      len;
   } utf8_type;

   function automatic hex_type hex_value(input logic [7:0] c);
      hex_type r;
      r.valid = 1'b1;
      r.value = c[3:0];
      if (c inside {[8'h30:8'h39]}) begin
         r.value = c[3:0];
      end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
         r.value = 4'(c[3:0] + 4'd9);
      end else begin
         r.valid = 1'b0;
      end
      return r;
   endfunction

   function automatic esc_type simple_escape(input logic [7:0] c);
      esc_type r;
      r.valid = 1'b1;
      case (c)
         CH_QUOTE:     r.value = CH_QUOTE;
         CH_BACKSLASH: r.value = CH_BACKSLASH;
         CH_SLASH:     r.value = CH_SLASH;
         8'h62:        r.value = 8'h08;
         8'h66:        r.value = 8'h0C;
         8'h6E:        r.value = 8'h0A;
         8'h72:        r.value = 8'h0D;
         8'h74:        r.value = 8'h09;
         default: begin
            r.valid = 1'b0;
            r.value = 8'h00;
         end
      endcase
      return r;
   endfunction

   function automatic utf8_type utf8_encode(input logic [CP_W-1:0] cp);
      utf8_type r;
      r.bytes = '0;
      if (cp < 21'h80) begin
         r.bytes[0] = cp[7:0];
         r.len      = 3'd1;
      end else if (cp < 21'h800) begin
         r.bytes[0] = 8'hC0 | {3'b000, cp[10:6]};
         r.bytes[1] = 8'h80 | {2'b00, cp[5:0]};
         r.len      = 3'd2;
      end else if (cp < 21'h10000) begin
         r.bytes[0] = 8'hE0 | {4'b0000, cp[15:12]};
         r.bytes[1] = 8'h80 | {2'b00, cp[11:6]};
         r.bytes[2] = 8'h80 | {2'b00, cp[5:0]};
         r.len      = 3'd3;
      end else begin
         r.bytes[0] = 8'hF0 | {5'b00000, cp[20:18]};
         r.bytes[1] = 8'h80 | {2'b00, cp[17:12]};
         r.bytes[2] = 8'h80 | {2'b00, cp[11:6]};
         r.bytes[3] = 8'h80 | {2'b00, cp[5:0]};
         r.len      = 3'd4;
      end
      return r;
   endfunction

endpackage

// File: rtl/jsu_if.sv
// ----------------------------------------------------------------------------
// jsu_if - channel interfaces of the JSON string unescaper
// Request channel carries text bytes and end-of-text marks; response channel
// carries decoded bytes, completion and error results.
// ----------------------------------------------------------------------------
interface jsu_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] in_byte;

   modport source (output valid, output func, output in_byte, input ready);
   modport sink   (input valid, input func, input in_byte, output ready);
endinterface

interface jsu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [1:0] out_kind;
   logic [2:0] error_code;
   logic       last;

   modport source (output valid, output out_byte, output out_kind,
                   output error_code, output last, input ready);
   modport sink   (input valid, input out_byte, input out_kind,
                   input error_code, input last, output ready);
endinterface

// File: rtl/jsu_decode.sv
// ----------------------------------------------------------------------------
// jsu_decode - one-byte step of the JSON string unescaper
// From the current state and one request item, computes the next state and
// the full list of results that the item causes.
// ----------------------------------------------------------------------------
module jsu_decode (
   input  jsu_pkg::state_type       state_cur,
   input  logic                     func,
   input  logic [7:0]               in_byte,
   output jsu_pkg::state_type       state_nxt,
   output jsu_pkg::result_list_type results
);
   import jsu_pkg::*;

   result_type [3:0]  main_e;
   logic [2:0]        main_len;
   logic              flush;
   logic              hold_new;
   err_type           err;
   hex_type           hexv;
   esc_type           escv;
   logic [15:0]       acc_next;
   logic              is_low;
   logic              is_high;
   logic [CP_W-1:0]   cp_combined;
   logic [CP_W-1:0]   cp_sel;
   utf8_type          enc;

   assign hexv        = hex_value(in_byte);
   assign escv        = simple_escape(in_byte);
   assign acc_next    = {state_cur.hex_accum[11:0], hexv.value};
   assign is_low      = (acc_next >= SURR_LOW_MIN) && (acc_next <= SURR_LOW_MAX);
   assign is_high     = (acc_next >= SURR_HIGH_MIN) && (acc_next <= SURR_HIGH_MAX);
   assign cp_combined = CP_SUPP_BASE + {1'b0, state_cur.pending_high, acc_next[9:0]};

   // A completed escape names a low surrogate after a held high one, a new
   // high surrogate to hold, or a plain code point (NUL and stray lows are
   // replaced).
   always_comb begin
      if (state_cur.pending_valid && is_low) begin
         cp_sel = cp_combined;
      end else if (acc_next == 16'd0 || is_low) begin
         cp_sel = CP_REPLACEMENT;
      end else begin
         cp_sel = {5'b00000, acc_next};
      end
   end

   assign enc = utf8_encode(cp_sel);

   always_comb begin
      state_nxt = state_cur;
      flush     = 1'b0;
      hold_new  = 1'b0;
      err       = ERR_NONE;
      main_len  = 3'd0;
      for (int i = 0; i < 4; i++) begin
         main_e[i] = '{data: 8'h00, kind: KIND_DATA, code: ERR_NONE};
      end

      if (func) begin
         if (state_cur.mode == MODE_STR || state_cur.mode == MODE_ESC ||
             state_cur.mode == MODE_HEX) begin
            err = ERR_UNTERM;
         end else begin
            state_nxt.mode = MODE_WAIT;
         end
      end else begin
         case (state_cur.mode)
            MODE_STR: begin
               if (in_byte == CH_QUOTE) begin
                  flush          = state_cur.pending_valid;
                  main_e[0].kind = KIND_DONE;
                  main_len       = 3'd1;
                  state_nxt.mode = MODE_WAIT;
               end else if (in_byte < CH_SPACE) begin
                  err = ERR_CTRL;
               end else if (in_byte == CH_BACKSLASH) begin
                  state_nxt.mode = MODE_ESC;
               end else begin
                  flush          = state_cur.pending_valid;
                  main_e[0].data = in_byte;
                  main_len       = 3'd1;
               end
            end
            MODE_ESC: begin
               if (in_byte == CH_U) begin
                  state_nxt.mode      = MODE_HEX;
                  state_nxt.hex_count = 2'd0;
                  state_nxt.hex_accum = 16'd0;
               end else if (escv.valid) begin
                  flush          = state_cur.pending_valid;
                  main_e[0].data = escv.value;
                  main_len       = 3'd1;
                  state_nxt.mode = MODE_STR;
               end else begin
                  err = ERR_ESCAPE;
               end
            end
            MODE_HEX: begin
               if (!hexv.valid) begin
                  err = ERR_HEX;
               end else begin
                  state_nxt.hex_accum = acc_next;
                  if (state_cur.hex_count != 2'd3) begin
                     state_nxt.hex_count = 2'(state_cur.hex_count + 2'd1);
                  end else begin
                     state_nxt.hex_count = 2'd0;
                     state_nxt.mode      = MODE_STR;
                     if (state_cur.pending_valid && is_low) begin
                        main_len = enc.len;
                     end else begin
                        flush = state_cur.pending_valid;
                        if (is_high) begin
                           hold_new = 1'b1;
                        end else begin
                           main_len = enc.len;
                        end
                     end
                     for (int i = 0; i < 4; i++) begin
                        main_e[i].data = enc.bytes[i];
                     end
                  end
               end
            end
            default: begin
               // Waiting for an opening quote; unused codes behave the same.
               if (in_byte == CH_QUOTE) begin
                  state_nxt.mode = MODE_STR;
               end else begin
                  err = ERR_NO_QUOTE;
               end
            end
         endcase
      end

      // A new high surrogate is held even when an older one is flushed in
      // the same step. The combining branch clears the held surrogate too.
      if (hold_new) begin
         state_nxt.pending_high  = 10'(acc_next - SURR_HIGH_MIN);
         state_nxt.pending_valid = 1'b1;
      end else if (flush || (main_len != 3'd0 && state_cur.mode == MODE_HEX &&
                             state_cur.pending_valid && is_low)) begin
         state_nxt.pending_valid = 1'b0;
         state_nxt.pending_high  = 10'd0;
      end

      results = '0;
      if (err != ERR_NONE) begin
         state_nxt             = STATE_RESET;
         results.entry[0].data = 8'h00;
         results.entry[0].kind = KIND_ERR;
         results.entry[0].code = err;
         results.count         = RES_CNT_W'(1);
      end else if (flush) begin
         results.entry[0] = '{data: FFFD_B0, kind: KIND_DATA, code: ERR_NONE};
         results.entry[1] = '{data: FFFD_B1, kind: KIND_DATA, code: ERR_NONE};
         results.entry[2] = '{data: FFFD_B2, kind: KIND_DATA, code: ERR_NONE};
         for (int i = 0; i < 3; i++) begin
            results.entry[i+3] = main_e[i];
         end
         results.count = RES_CNT_W'(main_len + 3'd3);
      end else begin
         for (int i = 0; i < 4; i++) begin
            results.entry[i] = main_e[i];
         end
         results.count = RES_CNT_W'(main_len);
      end
   end

endmodule

// File: rtl/json_string_unescape_utf8.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf8 - JSON quoted-string checker and UTF-8 unescaper
// Decodes the bytes of JSON strings one per transfer into UTF-8 bytes,
// completion marks and error results.
// ----------------------------------------------------------------------------
// Usage. The request channel (req_ch) takes one item per transfer: func = 0
// carries one text byte in in_byte, func = 1 marks the end of the text. The
// response channel (rsp_ch) gives one result per transfer: a decoded byte, a
// string-complete mark or an error with its code; last is set on the final
// result that one request item causes. An item may cause no result at all.
// A request item lands in an input register on its transfer. From there the
// decoder works out its whole result list (up to six entries) and the state
// update, which are written into the result buffer once the buffer is free;
// the results of an item are offered from that buffer.
// Throughput is one request item per cycle while every item causes at most
// one result and the receiver does not stall; an item with several results
// holds the result buffer until the response channel has drained its
// entries, one per cycle while the receiver accepts them.
// When the receiver stalls, the buffer holds its entries and one further
// request item waits in the input register; after that, req_ch.ready drops.
// Synchronous reset returns the decoder to waiting for an opening quote with
// no held surrogate and empties both the input register and the buffer.
// After an error result the consumer drops bytes already given for that
// string.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8 (
   input logic       clock,
   input logic       reset,
   jsu_req_if.sink   req_ch,
   jsu_rsp_if.source rsp_ch
);
   import jsu_pkg::*;

   // Input register stage.
   logic       in_valid_ff;
   logic       in_func_ff;
   logic [7:0] in_byte_ff;

   // Decoder state.
   state_type  state_ff;
   state_type  state_in;

   // Result buffer: entries of one item, drained one per transfer.
   result_type [MAX_RESULTS-1:0] buf_ff;
   logic [RES_CNT_W-1:0]         count_ff;
   logic [RES_IDX_W-1:0]         idx_ff;

   result_list_type dec;
   result_type      cur;
   logic            req_xfer;
   logic            rsp_xfer;
   logic            buf_last;
   logic            buf_free;
   logic            move;

   jsu_decode u_decode (
      .state_cur (state_ff),
      .func      (in_func_ff),
      .in_byte   (in_byte_ff),
      .state_nxt (state_in),
      .results   (dec)
   );

   assign req_xfer = req_ch.valid && req_ch.ready;
   assign rsp_xfer = rsp_ch.valid && rsp_ch.ready;
   assign buf_last = (RES_CNT_W'(idx_ff) == count_ff - RES_CNT_W'(1));
   // The buffer can be reloaded when it is empty or its final entry leaves
   // in this cycle.
   assign buf_free = (count_ff == '0) || (rsp_xfer && buf_last);
   assign move     = in_valid_ff && buf_free;

   assign req_ch.ready = !in_valid_ff || move;

   assign cur               = buf_ff[idx_ff];
   assign rsp_ch.valid      = (count_ff != '0);
   assign rsp_ch.out_byte   = cur.data;
   assign rsp_ch.out_kind   = cur.kind;
   assign rsp_ch.error_code = cur.code;
   assign rsp_ch.last       = buf_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= STATE_RESET;
         count_ff    <= '0;
         idx_ff      <= '0;
      end else begin
         if (req_xfer) begin
            in_valid_ff <= 1'b1;
         end else if (move) begin
            in_valid_ff <= 1'b0;
         end

         if (move) begin
            state_ff <= state_in;
            count_ff <= dec.count;
            idx_ff   <= '0;
         end else if (rsp_xfer) begin
            if (buf_last) begin
               count_ff <= '0;
               idx_ff   <= '0;
            end else begin
               idx_ff <= RES_IDX_W'(idx_ff + RES_IDX_W'(1));
            end
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_func_ff <= req_ch.func;
         in_byte_ff <= req_ch.in_byte;
      end
      if (move) begin
         buf_ff <= dec.entry;
      end
   end

`ifndef SYNTHESIS
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != '0 |-> RES_CNT_W'(idx_ff) < count_ff)
      else $error("result index beyond buffer fill");

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= RES_CNT_W'(MAX_RESULTS))
      else $error("result buffer overfilled");

   a_nondata_last: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.out_kind != KIND_DATA |-> rsp_ch.last)
      else $error("completion or error result not marked last");

   a_err_resets: assert property (@(posedge clock) disable iff (reset)
      move && dec.count != '0 && dec.entry[0].kind == KIND_ERR
      |=> state_ff.mode == MODE_WAIT && !state_ff.pending_valid)
      else $error("error did not return decoder to waiting");
`endif

endmodule
